### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define MSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that an antecedent implies a consequent in the next cycle.
`define MSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/msr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msr_pkg
// Slot codes, constants and reshaping functions of the syllable reorderer.
// ----------------------------------------------------------------------------
package msr_pkg;

  localparam int unsigned NumSlots = 17;
  localparam int unsigned SlotW    = 5;

  typedef logic [15:0] code_t;
  typedef code_t [NumSlots-1:0] slots_t;

  localparam logic [SlotW-1:0] SL_EV = 5'd0;
  localparam logic [SlotW-1:0] SL_RA = 5'd1;
  localparam logic [SlotW-1:0] SL_CO = 5'd2;
  localparam logic [SlotW-1:0] SL_C2 = 5'd3;
  localparam logic [SlotW-1:0] SL_ST = 5'd4;
  localparam logic [SlotW-1:0] SL_UV = 5'd5;
  localparam logic [SlotW-1:0] SL_HA = 5'd6;
  localparam logic [SlotW-1:0] SL_WA = 5'd7;
  localparam logic [SlotW-1:0] SL_YA = 5'd8;
  localparam logic [SlotW-1:0] SL_VI = 5'd9;
  localparam logic [SlotW-1:0] SL_AN = 5'd10;
  localparam logic [SlotW-1:0] SL_LV = 5'd11;
  localparam logic [SlotW-1:0] SL_AI = 5'd12;
  localparam logic [SlotW-1:0] SL_AA = 5'd13;
  localparam logic [SlotW-1:0] SL_DB = 5'd14;
  localparam logic [SlotW-1:0] SL_VS = 5'd15;
  localparam logic [SlotW-1:0] SL_OT = 5'd16;

  // Datapath commands issued by the controller.
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_STORE,
    CMD_RESHAPE,
    CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [SlotW-1:0] emit_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic  has_cons;
    logic  emit_nz;
    code_t emit_code;
    logic  late_uv;
    logic  late_vi;
  } dp_stat_t;

  function automatic logic [SlotW-1:0] classify(input code_t c);
    logic [SlotW-1:0] r;
    begin
      if ((c >= 16'h1000 && c <= 16'h102A) || (c >= 16'h103F && c <= 16'h1057) ||
          (c >= 16'hAA60 && c <= 16'hAA7B)) begin
        r = SL_CO;
      end else begin
        case (c)
          16'h1031: r = SL_EV;
          16'h103C: r = SL_RA;
          16'h102D, 16'h102E: r = SL_UV;
          16'h103E: r = SL_HA;
          16'h103D: r = SL_WA;
          16'h103B: r = SL_YA;
          16'h1036: r = SL_AN;
          16'h102F, 16'h1030: r = SL_LV;
          16'h1032: r = SL_AI;
          16'h102B, 16'h102C: r = SL_AA;
          16'h103A: r = SL_VI;
          16'h1037: r = SL_DB;
          16'h1038: r = SL_VS;
          default: r = SL_OT;
        endcase
      end
      return r;
    end
  endfunction

  function automatic logic is_long_cons(input code_t c);
    logic r;
    begin
      case (c)
        16'h1008, 16'h100B, 16'h100C, 16'h100D, 16'h1020, 16'h1025, 16'h1026,
        16'h106A, 16'h104C, 16'h104D, 16'h1092, 16'h106E, 16'h106F, 16'h1097,
        16'h1042, 16'h1043, 16'h1044, 16'h1045, 16'h1046, 16'h1047,
        16'h1049: r = 1'b1;
        default: r = 1'b0;
      endcase
      return r;
    end
  endfunction

  function automatic logic is_long_dbl(input code_t c);
    logic r;
    begin
      case (c)
        16'h100A, 16'h1009, 16'h106B, 16'h1023, 16'h1024, 16'h1029, 16'h102A,
        16'h104E, 16'h1091: r = 1'b1;
        default: r = 1'b0;
      endcase
      return r;
    end
  endfunction

  function automatic logic is_dot_cons(input code_t c);
    logic r;
    begin
      case (c)
        16'h1008, 16'h100B, 16'h100C, 16'h100D, 16'h1020, 16'h101B, 16'h1090,
        16'h104C, 16'h104D, 16'h1092, 16'h106E, 16'h106F, 16'h1097, 16'h1042,
        16'h1043, 16'h1044, 16'h1045, 16'h1046, 16'h1047, 16'h1049: r = 1'b1;
        default: r = 1'b0;
      endcase
      return r;
    end
  endfunction

  function automatic logic is_dot_dbl(input code_t c);
    logic r;
    begin
      case (c)
        16'h1023, 16'h1024, 16'h1029, 16'h102A, 16'h104E, 16'h1091: r = 1'b1;
        default: r = 1'b0;
      endcase
      return r;
    end
  endfunction

  function automatic logic is_tall_aa(input code_t c);
    logic r;
    begin
      case (c)
        16'h1001, 16'h1002, 16'h1004, 16'h1012, 16'h1015, 16'h101D: r = 1'b1;
        default: r = 1'b0;
      endcase
      return r;
    end
  endfunction

  // Writes one code into the store, expanding composite codes.
  function automatic slots_t store_code(input slots_t si, input code_t c);
    slots_t s;
    logic [SlotW-1:0] sl;
    begin
      s  = si;
      sl = classify(c);
      case (c)
        16'h102A: begin
          s[SL_EV] = 16'h1031; s[SL_RA] = 16'h107E; s[SL_C2] = 16'h101E;
          s[SL_AA] = 16'h102C; s[SL_VI] = 16'h1039;
        end
        16'h1029: begin
          s[SL_RA] = 16'h107E; s[SL_C2] = 16'h101E;
        end
        16'h1026: begin
          s[SL_UV] = 16'h102E; s[SL_CO] = 16'h1025;
        end
        16'h104E: begin
          s[SL_CO] = 16'h1044; s[SL_ST] = 16'h1004; s[SL_VI] = 16'h1039;
          s[SL_VS] = 16'h1038;
        end
        default: begin
          if (sl != SL_OT) s[sl] = c;
        end
      endcase
      return s;
    end
  endfunction

  // Applies all shaping rules in their fixed order when a consonant is in the store.
  function automatic slots_t reshape(input slots_t si);
    slots_t s;
    logic up, lo, lng, dbn;
    begin
      s = si;
      if (s[SL_CO] != 16'h0 || s[SL_C2] != 16'h0) begin
        if (s[SL_RA] != 16'h0) begin
          up = s[SL_UV] != 16'h0 || s[SL_AI] != 16'h0 || s[SL_AN] != 16'h0 ||
               s[SL_VI] == 16'h1064 || s[SL_VI] == 16'h108D;
          lo = s[SL_WA] != 16'h0 || s[SL_ST] != 16'h0;
          if (s[SL_CO] != 16'h0)
            s[SL_RA] = (up && lo) ? 16'h1083 : up ? 16'h107F : lo ? 16'h1081 : 16'h103B;
          else
            s[SL_RA] = (up && lo) ? 16'h1084 : up ? 16'h1080 : lo ? 16'h1082 : 16'h107E;
        end
        if (s[SL_C2] == 16'h100A || s[SL_C2] == 16'h106B)
          s[SL_C2] = (s[SL_WA] != 16'h0 || s[SL_ST] != 16'h0) ? 16'h106B : 16'h100A;
        if (s[SL_CO] == 16'h1014 || s[SL_CO] == 16'h108F)
          s[SL_CO] = (s[SL_RA] != 16'h0 || s[SL_WA] != 16'h0 || s[SL_HA] != 16'h0 ||
                      s[SL_YA] != 16'h0 || s[SL_LV] != 16'h0 || s[SL_ST] != 16'h0)
                     ? 16'h108F : 16'h1014;
        if (s[SL_CO] == 16'h101B || s[SL_CO] == 16'h1090)
          s[SL_CO] = (s[SL_LV] != 16'h0) ? 16'h1090 : 16'h101B;
        if (s[SL_CO] == 16'h1025 || s[SL_CO] == 16'h106A)
          s[SL_CO] = (s[SL_WA] != 16'h0 || s[SL_ST] != 16'h0) ? 16'h106A : 16'h1025;
        // Stacked pairs are checked in order; each rewrite stays within its own pair.
        if (s[SL_ST] == 16'h1066 || s[SL_ST] == 16'h1067)
          s[SL_ST] = (s[SL_C2] != 16'h0) ? 16'h1066 : 16'h1067;
        if (s[SL_ST] == 16'h1071 || s[SL_ST] == 16'h1072)
          s[SL_ST] = (s[SL_C2] != 16'h0) ? 16'h1071 : 16'h1072;
        if (s[SL_ST] == 16'h1073 || s[SL_ST] == 16'h1074)
          s[SL_ST] = (s[SL_C2] != 16'h0) ? 16'h1073 : 16'h1074;
        if (s[SL_ST] == 16'h107B || s[SL_ST] == 16'h1093)
          s[SL_ST] = (s[SL_C2] != 16'h0) ? 16'h107B : 16'h1093;
        if (s[SL_UV] != 16'h0) begin
          if (s[SL_VI] == 16'h1064) begin
            s[SL_UV] = (s[SL_UV] == 16'h102D) ? 16'h108B : 16'h108C;
            s[SL_VI] = 16'h0;
          end else if (s[SL_AN] != 16'h0) begin
            s[SL_UV] = 16'h108E; s[SL_AN] = 16'h0;
          end else if (s[SL_UV] == 16'h102D || s[SL_UV] == 16'h108B ||
                       s[SL_UV] == 16'h108E) begin
            s[SL_UV] = 16'h102D;
          end else if (s[SL_UV] == 16'h102E || s[SL_UV] == 16'h108C) begin
            s[SL_UV] = 16'h102E;
          end
        end
        if (s[SL_HA] != 16'h0)
          s[SL_HA] = (s[SL_RA] != 16'h0 || s[SL_C2] == 16'h100A || s[SL_C2] == 16'h1009 ||
                      s[SL_C2] == 16'h106B || s[SL_CO] == 16'h100C ||
                      s[SL_C2] == 16'h1029 || s[SL_C2] == 16'h102A) ? 16'h1087 : 16'h103D;
        if (s[SL_WA] != 16'h0) begin
          if (s[SL_HA] != 16'h0) begin
            s[SL_WA] = 16'h108A; s[SL_HA] = 16'h0;
          end else begin
            s[SL_WA] = 16'h103C;
          end
        end
        if (s[SL_YA] != 16'h0) s[SL_YA] = (s[SL_WA] != 16'h0) ? 16'h107D : 16'h103A;
        if (s[SL_LV] != 16'h0) begin
          lng = s[SL_RA] != 16'h0 || s[SL_YA] != 16'h0 || s[SL_WA] != 16'h0 ||
                s[SL_ST] != 16'h0 || is_long_cons(s[SL_CO]) || is_long_dbl(s[SL_C2]);
          if (s[SL_LV] == 16'h102F || s[SL_LV] == 16'h1033) begin
            if (lng) s[SL_LV] = 16'h1033;
            else if (s[SL_HA] != 16'h0) begin
              s[SL_LV] = 16'h1088; s[SL_HA] = 16'h0;
            end else s[SL_LV] = 16'h102F;
          end else begin
            if (lng) s[SL_LV] = 16'h1034;
            else if (s[SL_HA] != 16'h0) begin
              s[SL_LV] = 16'h1089; s[SL_HA] = 16'h0;
            end else s[SL_LV] = 16'h1030;
          end
        end
        if (s[SL_AA] != 16'h0) begin
          if (is_tall_aa(s[SL_CO]) && s[SL_RA] == 16'h0 && s[SL_ST] == 16'h0 &&
              s[SL_UV] == 16'h0 && s[SL_HA] == 16'h0 && s[SL_WA] == 16'h0 &&
              s[SL_YA] == 16'h0 && s[SL_LV] == 16'h0) begin
            if (s[SL_VI] == 16'h1039) begin
              s[SL_AA] = 16'h105A; s[SL_VI] = 16'h0;
            end else s[SL_AA] = 16'h102B;
          end else begin
            s[SL_AA] = 16'h102C;
          end
        end
        if (s[SL_VI] == 16'h1064 && s[SL_AN] != 16'h0) begin
          s[SL_VI] = 16'h108D; s[SL_AN] = 16'h0;
        end
        if (s[SL_DB] != 16'h0) begin
          dbn = s[SL_AA] == 16'h0;
          if (dbn && (s[SL_RA] != 16'h0 || s[SL_WA] != 16'h0 || s[SL_YA] != 16'h0 ||
              (s[SL_LV] != 16'h0 && s[SL_LV] != 16'h102F) || s[SL_ST] != 16'h0 ||
              is_dot_cons(s[SL_CO]) || is_dot_dbl(s[SL_C2])))
            s[SL_DB] = 16'h1095;
          else if (dbn && (s[SL_HA] != 16'h0 || s[SL_LV] == 16'h102F ||
                   s[SL_CO] == 16'h1014))
            s[SL_DB] = 16'h1094;
          else
            s[SL_DB] = 16'h1037;
        end
        if (s[SL_CO] == 16'h100D && s[SL_ST] == 16'h106E) begin
          s[SL_CO] = 16'h106E; s[SL_ST] = 16'h0;
        end
        if (s[SL_CO] == 16'h100E && s[SL_ST] == 16'h106F) begin
          s[SL_CO] = 16'h106F; s[SL_ST] = 16'h0;
        end
        if (s[SL_CO] == 16'h100B && s[SL_ST] == 16'h1097) begin
          s[SL_CO] = 16'h1097; s[SL_ST] = 16'h0;
        end
        if (s[SL_EV] == 16'h1031 && s[SL_RA] == 16'h107E && s[SL_C2] == 16'h101E &&
            s[SL_AA] == 16'h102C && s[SL_VI] == 16'h1039) begin
          s[SL_EV] = 16'h0; s[SL_RA] = 16'h0; s[SL_C2] = 16'h102A;
          s[SL_AA] = 16'h0; s[SL_VI] = 16'h0;
        end
        if (s[SL_RA] == 16'h107E && s[SL_C2] == 16'h101E) begin
          s[SL_RA] = 16'h0; s[SL_C2] = 16'h1029;
        end
        if (s[SL_UV] == 16'h102E && s[SL_CO] == 16'h1025) begin
          s[SL_UV] = 16'h0; s[SL_CO] = 16'h1026;
        end
        if (s[SL_CO] == 16'h1044 && s[SL_ST] == 16'h1004 && s[SL_VI] == 16'h1039 &&
            s[SL_VS] == 16'h1038) begin
          s[SL_CO] = 16'h104E; s[SL_ST] = 16'h0; s[SL_VI] = 16'h0; s[SL_VS] = 16'h0;
        end
        if (s[SL_CO] == 16'h1005 && s[SL_YA] == 16'h103A) begin
          s[SL_CO] = 16'h1008; s[SL_YA] = 16'h0;
        end
      end
      return s;
    end
  endfunction

endpackage

### hdl/msr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msr_in_if / msr_out_if
// Valid/ready channels carrying input code points and result code points.
// ----------------------------------------------------------------------------
interface msr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  logic        text_last;
  modport source (output valid, char_code, text_last, input ready);
  modport sink   (input valid, char_code, text_last, output ready);
endinterface

interface msr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_code;
  logic        run_last;
  logic        text_end;
  modport source (output valid, out_code, run_last, text_end, input ready);
  modport sink   (input valid, out_code, run_last, text_end, output ready);
endinterface

### hdl/msr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msr_datapath
// Syllable slot store with store, reshape and clear operations and emit read.
// ----------------------------------------------------------------------------
module msr_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  msr_pkg::dp_cmd_t          cmd_i,
  input  msr_pkg::code_t            code_i,
  output msr_pkg::dp_stat_t         stat_o
);
  import msr_pkg::*;

  slots_t slots_q, slots_d;

  always_comb begin
    case (cmd_i.cmd)
      CMD_STORE:   slots_d = store_code(slots_q, code_i);
      CMD_RESHAPE: slots_d = reshape(slots_q);
      CMD_CLEAR:   slots_d = '0;
      default:     slots_d = slots_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= '0;
    end else begin
      slots_q <= slots_d;
    end
  end

  always_comb begin
    stat_o.has_cons  = slots_q[SL_CO] != 16'h0 || slots_q[SL_C2] != 16'h0;
    stat_o.emit_code = (cmd_i.emit_idx <= SL_OT) ? slots_q[cmd_i.emit_idx] : 16'h0;
    stat_o.emit_nz   = stat_o.emit_code != 16'h0;
    stat_o.late_uv   = slots_q[SL_YA] != 16'h0;
    stat_o.late_vi   = !((slots_q[SL_EV] == 16'h0 && slots_q[SL_YA] != 16'h0 &&
                          slots_q[SL_VI] != 16'h0) ||
                         slots_q[SL_VI] == 16'h1064 || slots_q[SL_VI] == 16'h108D);
  end

endmodule

### hdl/msr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msr_ctrl
// Sequencer: classifies an item, runs flushes slot by slot and drives output.
// ----------------------------------------------------------------------------
module msr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  msr_pkg::code_t        in_code_i,
  input  logic                  in_last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output msr_pkg::code_t        out_code_o,
  output logic                  out_run_last_o,
  output logic                  out_text_end_o,
  output msr_pkg::dp_cmd_t      cmd_o,
  output msr_pkg::code_t        dp_code_o,
  input  msr_pkg::dp_stat_t     stat_i
);
  import msr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_RESHAPE,
    ST_EMIT,
    ST_CLEAR,
    ST_PLACE,
    ST_FINISH
  } state_e;

  state_e           state_q, state_d;
  code_t            code_q, code_d;
  logic             last_q, last_d;
  logic             second_q, second_d;   // flush after the item was placed
  logic [4:0]       pos_q, pos_d;         // display position, 0..17
  logic             pend_v_q, pend_v_d;   // one result held back for run_last
  code_t            pend_q, pend_d;
  logic             ov_q, ov_d;
  code_t            oc_q, oc_d;
  logic             orl_q, orl_d, ote_q, ote_d;
  logic [SlotW-1:0] pos_slot;
  logic             pos_en;
  logic             out_free;
  logic             is_ot;
  logic             step;

  // Display order position to slot, with the two movable slots. The other
  // slot is never written, so the walk ends at the visarga.
  always_comb begin
    pos_en = 1'b1;
    case (pos_q)
      5'd0:  pos_slot = SL_EV;
      5'd1:  pos_slot = SL_RA;
      5'd2:  pos_slot = SL_CO;
      5'd3:  pos_slot = SL_C2;
      5'd4:  pos_slot = SL_ST;
      5'd5:  begin pos_slot = SL_UV; pos_en = !stat_i.late_uv; end
      5'd6:  pos_slot = SL_HA;
      5'd7:  pos_slot = SL_WA;
      5'd8:  pos_slot = SL_YA;
      5'd9:  begin pos_slot = SL_VI; pos_en = !stat_i.late_vi; end
      5'd10: pos_slot = SL_AN;
      5'd11: pos_slot = SL_LV;
      5'd12: begin pos_slot = SL_UV; pos_en = stat_i.late_uv; end
      5'd13: pos_slot = SL_AI;
      5'd14: pos_slot = SL_AA;
      5'd15: begin pos_slot = SL_VI; pos_en = stat_i.late_vi; end
      5'd16: pos_slot = SL_DB;
      5'd17: pos_slot = SL_VS;
      default: pos_slot = SL_OT;
    endcase
  end

  assign is_ot    = classify(code_q) == SL_OT;
  assign out_free = !ov_q || out_ready_i;

  assign in_ready_o     = state_q == ST_IDLE;
  assign out_valid_o    = ov_q;
  assign out_code_o     = oc_q;
  assign out_run_last_o = orl_q;
  assign out_text_end_o = ote_q;
  assign dp_code_o      = code_q;

  always_comb begin
    state_d  = state_q;
    code_d   = code_q;
    last_d   = last_q;
    second_d = second_q;
    pos_d    = pos_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    ov_d     = ov_q && !out_ready_i;
    oc_d     = oc_q;
    orl_d    = orl_q;
    ote_d    = ote_q;
    step     = 1'b0;
    cmd_o.cmd      = CMD_NONE;
    cmd_o.emit_idx = pos_slot;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          code_d   = in_code_i;
          last_d   = in_last_i;
          second_d = 1'b0;
          pend_v_d = 1'b0;
          state_d  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // Decide whether the old syllable flushes before this item.
        if (stat_i.has_cons && (classify(code_q) <= SL_C2 || is_ot)) begin
          state_d = ST_RESHAPE;
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_RESHAPE: begin
        cmd_o.cmd = CMD_RESHAPE;
        pos_d     = 5'd0;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (pos_en && stat_i.emit_nz) begin
          // A new result pushes the held one out, which is then not the last.
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              ov_d = 1'b1; oc_d = pend_q; orl_d = 1'b0; ote_d = 1'b0;
            end
            pend_v_d = 1'b1;
            pend_d   = stat_i.emit_code;
            step     = 1'b1;
          end
        end else begin
          step = 1'b1;
        end
        if (step) begin
          if (pos_q == 5'd17) state_d = ST_CLEAR;
          else pos_d = pos_q + 5'd1;
        end
      end
      ST_CLEAR: begin
        cmd_o.cmd = CMD_CLEAR;
        state_d   = second_q ? ST_FINISH : ST_PLACE;
      end
      ST_PLACE: begin
        if (is_ot) begin
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              ov_d = 1'b1; oc_d = pend_q; orl_d = 1'b0; ote_d = 1'b0;
            end
            pend_v_d = 1'b1;
            pend_d   = code_q;
            step     = 1'b1;
          end
        end else begin
          cmd_o.cmd = CMD_STORE;
          step      = 1'b1;
        end
        if (step) begin
          if (last_q) begin
            second_d = 1'b1;
            state_d  = ST_RESHAPE;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        // Release the held result as the last one of this item.
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          ov_d = 1'b1; oc_d = pend_q; orl_d = 1'b1; ote_d = last_q;
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      second_q <= 1'b0;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
      pos_q    <= 5'd0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
      pend_v_q <= pend_v_d;
      ov_q     <= ov_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    last_q <= last_d;
    pend_q <= pend_d;
    oc_q   <= oc_d;
    orl_q  <= orl_d;
    ote_q  <= ote_d;
  end

endmodule

### hdl/myanmar_syllable_reorder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// myanmar_syllable_reorder_core
// Reorders Myanmar code points of a syllable into display order.
// ----------------------------------------------------------------------------
// One item is taken at a time. An item that causes no flush passes through the
// decide, place and finish states before the next item can be taken. Each flush
// reshapes the store, steps through the 18 display positions and clears the
// store; an item can cause two flushes, one before it is placed and
// one when it is the last of the text. A result that finds the output register
// still full stalls the sequencer until the receiver takes it.
module myanmar_syllable_reorder_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  msr_in_if.sink       in_if,
  msr_out_if.source    out_if
);
  import msr_pkg::*;
`include "assert_macros.svh"

  dp_cmd_t  cmd;
  dp_stat_t stat;
  code_t    dp_code;

  msr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_if.valid),
    .in_ready_o     (in_if.ready),
    .in_code_i      (in_if.char_code),
    .in_last_i      (in_if.text_last),
    .out_valid_o    (out_if.valid),
    .out_ready_i    (out_if.ready),
    .out_code_o     (out_if.out_code),
    .out_run_last_o (out_if.run_last),
    .out_text_end_o (out_if.text_end),
    .cmd_o          (cmd),
    .dp_code_o      (dp_code),
    .stat_i         (stat)
  );

  msr_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .code_i (dp_code),
    .stat_o (stat)
  );

  `MSR_ASSERT_IMP(a_end_is_last, clk_i, rst_ni, out_if.valid && out_if.text_end, out_if.run_last)
  `MSR_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, cmd.cmd == CMD_CLEAR, !stat.has_cons)

endmodule
